/* hdl/hets_pkg.sv */
package hets_pkg;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;     // load a new input word
        logic step;       // process one queued byte, or resolve a pending match at end
        logic end_reset;  // return parse state to reset at end of text
        logic rel_rd;     // read the next held tag byte
        logic rel_emit;   // emit the held tag byte just read
        logic rel_done;   // release finished: clear the hold store
        logic post_emit;  // emit the byte saved behind a release
        logic fin;        // close the word: hand the staged byte out with its marks
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic q_nonempty; // bytes wait in the replay queue
        logic pending;    // a '<' or '&' match is still open
        logic text_end;   // the current word carries the end mark
        logic want_emit;  // the next step emits a byte
        logic want_rel;   // the next step releases the hold store
        logic want_post;  // a byte follows that release
        logic can_emit;   // the staging register can take a byte
        logic rel_more;   // held bytes remain to release
        logic fin_ok;     // the output register can take the staged byte
    } t_stat;

endpackage

/* hdl/hets_ctrl.sv */
module hets_ctrl
    import hets_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_PROC     = 6'b000010,
        S_REL_RD   = 6'b000100,
        S_REL_EMIT = 6'b001000,
        S_POST     = 6'b010000,
        S_FIN      = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_post_emit, n_post_emit;
    logic   r_post_fin, n_post_fin;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_post_emit = r_post_emit;
        n_post_fin  = r_post_fin;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_PROC;
                end
            end
            S_PROC: begin
                if (i_stat.q_nonempty || (i_stat.text_end && i_stat.pending)) begin
                    if (!(i_stat.want_emit && !i_stat.can_emit)) begin
                        o_cmd.step = 1'b1;
                        if (i_stat.want_rel) begin
                            n_post_emit = i_stat.want_post;
                            n_post_fin  = 1'b0;
                            n_state     = S_REL_RD;
                        end
                    end
                end else if (i_stat.text_end) begin
                    o_cmd.end_reset = 1'b1;
                    n_post_emit     = 1'b0;
                    n_post_fin      = 1'b1;
                    n_state         = S_REL_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_REL_RD: begin
                if (i_stat.rel_more) begin
                    o_cmd.rel_rd = 1'b1;
                    n_state      = S_REL_EMIT;
                end else begin
                    o_cmd.rel_done = 1'b1;
                    if (r_post_emit)     n_state = S_POST;
                    else if (r_post_fin) n_state = S_FIN;
                    else                 n_state = S_PROC;
                end
            end
            S_REL_EMIT: begin
                if (i_stat.can_emit) begin
                    o_cmd.rel_emit = 1'b1;
                    n_state        = S_REL_RD;
                end
            end
            S_POST: begin
                if (i_stat.can_emit) begin
                    o_cmd.post_emit = 1'b1;
                    n_state         = S_PROC;
                end
            end
            S_FIN: begin
                if (i_stat.fin_ok) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_post_emit <= 1'b0;
            r_post_fin  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_post_emit <= n_post_emit;
            r_post_fin  <= n_post_fin;
        end
    end

endmodule

/* hdl/hets_dpath.sv */
module hets_dpath
    import hets_pkg::*;
#(
    parameter int TAG_HOLD_DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    output t_stat      o_stat,
    input  logic [7:0] i_in_char,
    input  logic       i_text_end,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    output logic [7:0] o_out_char,
    output logic       o_out_last,
    output logic       o_out_done
);

    localparam int AW  = (TAG_HOLD_DEPTH > 1) ? $clog2(TAG_HOLD_DEPTH) : 1;
    localparam int HCW = $clog2(TAG_HOLD_DEPTH + 1);
    localparam logic [HCW-1:0] HOLD_FULL = HCW'(TAG_HOLD_DEPTH);
    localparam logic [5:0] MAX_RESULTS = 6'd40;
    localparam int QD = 8;

    localparam logic [1:0] M_TEXT  = 2'd0;
    localparam logic [1:0] M_ANGLE = 2'd1;
    localparam logic [1:0] M_AMP   = 2'd2;
    localparam logic [1:0] M_NUM   = 2'd3;

    typedef logic [4:0][7:0] t_pat;

    localparam t_pat ANGLE_PAT [4] = '{
        '{8'h00, 8'h00, ">", "r", "b"},
        '{">", "/", " ", "r", "b"},
        '{8'h00, ">", "d", "t", "/"},
        '{8'h00, 8'h00, 8'h00, ">", "p"}
    };
    localparam logic [2:0] ANGLE_LEN [4] = '{3'd3, 3'd5, 3'd4, 3'd2};
    localparam logic [7:0] ANGLE_CODE [4] = '{8'd13, 8'd13, " ", 8'd13};

    localparam t_pat AMP_PAT [7] = '{
        '{";", "t", "o", "u", "q"},
        '{";", "p", "s", "b", "n"},
        '{8'h00, 8'h00, ";", "t", "l"},
        '{8'h00, 8'h00, ";", "t", "g"},
        '{8'h00, ";", "p", "m", "a"},
        '{";", "y", "p", "o", "c"},
        '{8'h00, 8'h00, 8'h00, 8'h00, "#"}
    };
    localparam logic [2:0] AMP_LEN [7] = '{3'd5, 3'd5, 3'd3, 3'd3, 3'd4, 3'd5, 3'd1};
    localparam logic [7:0] AMP_CODE [7] = '{"\"", "_", "<", ">", "&", 8'hA9, 8'h00};
    localparam int AMP_NUMERIC = 6;

    function automatic logic [7:0] map_code(input logic [31:0] v);
        logic [7:0] r;
        if (v < 32'h100)                       r = v[7:0];
        else if (v >= 32'h410 && v <= 32'h44F) r = v[7:0] + 8'hB0;
        else if (v == 32'h401)                 r = 8'hA8;
        else if (v == 32'h451)                 r = 8'hB8;
        else                                   r = "?";
        return r;
    endfunction

    function automatic logic pat_match(input logic [4:0][7:0] la, input logic [2:0] n,
                                       input t_pat p);
        logic ok;
        ok = 1'b1;
        for (int j = 0; j < 5; j++) begin
            if (3'(j) < n && la[j] != p[j]) ok = 1'b0;
        end
        return ok;
    endfunction

    logic [7:0]      r_q [QD];
    logic [3:0]      r_qcnt;
    logic [4:0][7:0] r_la;
    logic [2:0]      r_lacnt;
    logic [1:0]      r_mode;
    logic [31:0]     r_acc;
    logic            r_inside;
    logic [7:0]      r_mem [TAG_HOLD_DEPTH];
    logic [HCW-1:0]  r_hcnt;
    logic [HCW-1:0]  r_idx;
    logic [7:0]      r_rd;
    logic [7:0]      r_post_byte;
    logic            r_end;
    logic            r_h_valid;
    logic [7:0]      r_h_byte;
    logic            r_o_valid;
    logic [7:0]      r_o_byte;
    logic            r_o_last;
    logic            r_o_done;
    logic [5:0]      r_res;

    // Step decode
    logic [7:0]      b;
    logic            have;
    logic [4:0][7:0] la_new;
    logic [2:0]      n_la;
    logic [4:0][7:0] pre;
    logic [2:0]      pre_n;
    logic            put_req;
    logic [7:0]      put_val;
    logic            mis;
    logic [4:0][7:0] mis_la;
    logic [2:0]      mis_n;
    logic            clr_hold;
    logic            a_emit, a_hold, a_rel, a_post;
    logic [1:0]      s_mode;
    logic [2:0]      s_lacnt;
    logic [31:0]     s_acc;
    logic            s_inside;
    logic            full_hit, any_pre;
    logic [7:0]      full_code;
    logic            full_num;
    logic [7:0]      s_q [QD];
    logic [3:0]      s_qcnt;

    assign b    = r_q[0];
    assign have = (r_qcnt != 4'd0);

    always_comb begin
        la_new    = r_la;
        if (r_lacnt < 3'd5) la_new[r_lacnt] = b;
        n_la      = r_lacnt + 3'd1;
        full_hit  = 1'b0;
        any_pre   = 1'b0;
        full_code = 8'h00;
        full_num  = 1'b0;
        if (r_mode == M_ANGLE) begin
            for (int i = 0; i < 4; i++) begin
                if (pat_match(la_new, n_la, ANGLE_PAT[i])) begin
                    if (ANGLE_LEN[i] == n_la && !full_hit) begin
                        full_hit  = 1'b1;
                        full_code = ANGLE_CODE[i];
                    end
                    if (ANGLE_LEN[i] > n_la) any_pre = 1'b1;
                end
            end
        end else begin
            for (int i = 0; i < 7; i++) begin
                if (pat_match(la_new, n_la, AMP_PAT[i])) begin
                    if (AMP_LEN[i] == n_la && !full_hit) begin
                        full_hit  = 1'b1;
                        full_code = AMP_CODE[i];
                        full_num  = (i == AMP_NUMERIC);
                    end
                    if (AMP_LEN[i] > n_la) any_pre = 1'b1;
                end
            end
        end
    end

    always_comb begin
        s_mode   = r_mode;
        s_lacnt  = r_lacnt;
        s_acc    = r_acc;
        s_inside = r_inside;
        pre      = '0;
        pre_n    = 3'd0;
        put_req  = 1'b0;
        put_val  = b;
        mis      = 1'b0;
        mis_la   = r_la;
        mis_n    = r_lacnt;
        clr_hold = 1'b0;
        if (have) begin
            case (r_mode)
                M_TEXT: begin
                    if (b == "<") begin
                        s_mode  = M_ANGLE;
                        s_lacnt = 3'd0;
                    end else if (b == "&") begin
                        s_mode  = M_AMP;
                        s_lacnt = 3'd0;
                    end else if (b == ">" && r_inside) begin
                        clr_hold = 1'b1;
                        s_inside = 1'b0;
                    end else begin
                        put_req = 1'b1;
                    end
                end
                M_NUM: begin
                    if (b == ";") begin
                        pre[0] = map_code(r_acc);
                        pre_n  = 3'd1;
                        s_acc  = '0;
                        s_mode = M_TEXT;
                    end else begin
                        s_acc = (r_acc << 3) + (r_acc << 1) + {24'd0, b} - 32'd48;
                    end
                end
                default: begin
                    if (full_hit) begin
                        s_lacnt = 3'd0;
                        if (r_mode == M_ANGLE) begin
                            s_mode  = M_TEXT;
                            put_req = 1'b1;
                            put_val = full_code;
                        end else if (full_num) begin
                            s_mode = M_NUM;
                            s_acc  = '0;
                        end else begin
                            s_mode = M_TEXT;
                            pre[0] = full_code;
                            pre_n  = 3'd1;
                        end
                    end else if (!any_pre || n_la >= 3'd5) begin
                        mis    = 1'b1;
                        mis_la = la_new;
                        mis_n  = n_la;
                    end else begin
                        s_lacnt = n_la;
                    end
                end
            endcase
        end else begin
            mis = 1'b1;
        end
        if (have && (r_mode == M_ANGLE || r_mode == M_AMP) && !mis && !full_hit) begin
            // hold the extended lookahead
            s_lacnt = n_la;
        end
        a_rel  = 1'b0;
        if (mis) begin
            pre     = mis_la;
            pre_n   = mis_n;
            s_lacnt = 3'd0;
            s_mode  = M_TEXT;
            if (r_mode == M_ANGLE) begin
                a_rel    = 1'b1;
                s_inside = 1'b1;
            end else begin
                put_req = 1'b1;
                put_val = "&";
            end
        end
        a_emit = 1'b0;
        a_hold = 1'b0;
        a_post = 1'b0;
        if (put_req) begin
            if (!r_inside) begin
                a_emit = 1'b1;
            end else if (r_hcnt < HOLD_FULL) begin
                a_hold = 1'b1;
            end else begin
                a_rel    = 1'b1;
                a_post   = 1'b1;
                s_inside = 1'b0;
            end
        end
    end

    // Queue update: drop the consumed byte, prepend replayed bytes
    always_comb begin
        logic [7:0] base [QD];
        logic [3:0] bcnt;
        for (int i = 0; i < QD; i++) begin
            base[i] = (have && i < QD - 1) ? r_q[i+1] : (have ? 8'h00 : r_q[i]);
        end
        bcnt   = have ? r_qcnt - 4'd1 : r_qcnt;
        for (int i = 0; i < QD; i++) begin
            if (4'(i) < {1'b0, pre_n}) s_q[i] = pre[i % 5];
            else                       s_q[i] = base[(i - int'(pre_n)) % QD];
        end
        s_qcnt = bcnt + {1'b0, pre_n};
    end

    // Emission through the staging register
    logic       do_emit;
    logic [7:0] emit_byte;
    logic       can_emit;

    assign can_emit = !r_h_valid || !r_o_valid || i_out_ready;
    assign do_emit  = (i_cmd.step && a_emit) || i_cmd.rel_emit || i_cmd.post_emit;
    always_comb begin
        if (i_cmd.rel_emit)       emit_byte = r_rd;
        else if (i_cmd.post_emit) emit_byte = r_post_byte;
        else                      emit_byte = put_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qcnt    <= '0;
            r_lacnt   <= '0;
            r_mode    <= M_TEXT;
            r_acc     <= '0;
            r_inside  <= 1'b0;
            r_hcnt    <= '0;
            r_idx     <= '0;
            r_end     <= 1'b0;
            r_h_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_res     <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_q[0] <= i_in_char;
                r_qcnt <= 4'd1;
                r_end  <= i_text_end;
            end
            if (i_cmd.step) begin
                r_q         <= s_q;
                r_qcnt      <= s_qcnt;
                r_la        <= (have && !mis) ? la_new : r_la;
                r_lacnt     <= s_lacnt;
                r_mode      <= s_mode;
                r_acc       <= s_acc;
                r_inside    <= s_inside;
                r_post_byte <= put_val;
                if (clr_hold) r_hcnt <= '0;
                if (a_hold) begin
                    r_mem[r_hcnt[AW-1:0]] <= put_val;
                    r_hcnt                <= r_hcnt + HCW'(1);
                end
            end
            if (i_cmd.end_reset) begin
                r_lacnt  <= '0;
                r_mode   <= M_TEXT;
                r_acc    <= '0;
                r_inside <= 1'b0;
            end
            if (i_cmd.rel_rd) begin
                r_rd <= r_mem[r_idx[AW-1:0]];
            end
            if (i_cmd.rel_emit) begin
                r_idx <= r_idx + HCW'(1);
            end
            if (i_cmd.rel_done) begin
                r_idx  <= '0;
                r_hcnt <= '0;
            end

            if (i_cmd.fin && r_h_valid) begin
                r_o_valid <= 1'b1;
                r_o_byte  <= r_h_byte;
                r_o_last  <= 1'b1;
                r_o_done  <= r_end;
            end else if (do_emit && r_res < MAX_RESULTS && r_h_valid) begin
                r_o_valid <= 1'b1;
                r_o_byte  <= r_h_byte;
                r_o_last  <= 1'b0;
                r_o_done  <= 1'b0;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end

            if (i_cmd.fin) begin
                r_h_valid <= 1'b0;
                r_res     <= '0;
                r_end     <= 1'b0;
            end else if (do_emit && r_res < MAX_RESULTS) begin
                r_h_valid <= 1'b1;
                r_h_byte  <= emit_byte;
                r_res     <= r_res + 6'd1;
            end
        end
    end

    assign o_stat.q_nonempty = have;
    assign o_stat.pending    = (r_mode == M_ANGLE) || (r_mode == M_AMP);
    assign o_stat.text_end   = r_end;
    assign o_stat.want_emit  = a_emit;
    assign o_stat.want_rel   = a_rel;
    assign o_stat.want_post  = a_post;
    assign o_stat.can_emit   = can_emit;
    assign o_stat.rel_more   = (r_idx < r_hcnt);
    assign o_stat.fin_ok     = !r_h_valid || !r_o_valid || i_out_ready;

    assign o_out_valid = r_o_valid;
    assign o_out_char  = r_o_byte;
    assign o_out_last  = r_o_last;
    assign o_out_done  = r_o_done;

endmodule

/* hdl/html_entity_tag_stripper_unit.sv */
// Flow: an accepted word enters the replay queue, a step moves a plain byte into the
//   staging register, and the close moves the staged byte to the output register; the
//   last byte of a word waits for the close, earlier ones leave as the next is staged.
// Sequence: accept, step, empty-queue check, close; a replayed byte adds a step, a held
//   byte a read and an emit, a release an end, end of text an end reset; output stalls wait.
// Reset: synchronous, active low; clears parse mode, counts, queue and output valid.
module html_entity_tag_stripper_unit
    import hets_pkg::*;
#(
    parameter int TAG_HOLD_DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_char
    input  logic       s_axis_tlast,   // text_end
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_char
    output logic       m_axis_tlast,   // run_last
    output logic       m_axis_tuser    // [0] text_done
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // Controller: sequences steps, hold releases and the close of each word
    hets_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Datapath: replay queue, lookahead matcher, numeric accumulator,
    // tag hold memory, staging and output registers
    hets_dpath #(
        .TAG_HOLD_DEPTH (TAG_HOLD_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_char   (s_axis_tdata),
        .i_text_end  (s_axis_tlast),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_char  (m_axis_tdata),
        .o_out_last  (m_axis_tlast),
        .o_out_done  (m_axis_tuser)
    );

endmodule

/* hdl/hets_checker.sv */
module hets_props (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic       s_axis_tlast,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic       m_axis_tuser
);

    // End of text is flagged only on the last byte of a word
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("text_done without run_last");

    // One word at a time: no acceptance right after one
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted in consecutive cycles");

    // Stalled output holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("stalled output changed");

endmodule

bind html_entity_tag_stripper_unit hets_props u_hets_props (.*);

/* dv/hets_checker.sv */
module hets_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic       i_s_tready,
    input  logic [7:0] i_s_tdata,
    input  logic       i_s_tlast,
    input  logic       i_m_tvalid,
    input  logic       i_m_tready,
    input  logic [7:0] i_m_tdata,
    input  logic       i_m_tlast,
    input  logic       i_m_tuser,
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_DEPTH = 32;
    localparam int LOOK_DEPTH = 5;
    localparam int MAX_BYTES  = 40;

    typedef enum logic [1:0] {
        MODE_TEXT  = 2'd0,
        MODE_ANGLE = 2'd1,
        MODE_AMP   = 2'd2,
        MODE_NUM   = 2'd3
    } t_mode;

    typedef struct packed {
        logic [7:0] ch;
        logic       run_last;
        logic       text_done;
    } t_out_word;

    logic [7:0]  look_buf [LOOK_DEPTH];
    int          look_cnt;
    t_mode       mode;
    logic [7:0]  hold_buf [HOLD_DEPTH];
    int          hold_cnt;
    logic        in_tag;
    logic [31:0] num_acc;

    t_out_word   step_bytes [$];
    t_out_word   expected_words [$];

    assign o_pending = expected_words.size();

    function automatic void clear_state();
        look_cnt = 0;
        mode     = MODE_TEXT;
        hold_cnt = 0;
        in_tag   = 1'b0;
        num_acc  = '0;
    endfunction

    function automatic void push_byte(logic [7:0] b);
        t_out_word w;
        if (step_bytes.size() < MAX_BYTES) begin
            w.ch = b;
            w.run_last = 1'b0;
            w.text_done = 1'b0;
            step_bytes.push_back(w);
        end
    endfunction

    function automatic void release_hold();
        for (int i = 0; i < hold_cnt; i++) push_byte(hold_buf[i]);
        hold_cnt = 0;
    endfunction

    function automatic void put_char(logic [7:0] b);
        if (!in_tag) begin
            push_byte(b);
        end else if (hold_cnt < HOLD_DEPTH) begin
            hold_buf[hold_cnt] = b;
            hold_cnt++;
        end else begin
            // store full: give up on the tag and pass everything through
            release_hold();
            push_byte(b);
            in_tag = 1'b0;
        end
    endfunction

    function automatic logic [7:0] map_code(logic [31:0] v);
        if (v < 32'h100) return v[7:0];
        if (v >= 32'h410 && v <= 32'h44F) return 8'(v - 32'h410 + 32'hC0);
        if (v == 32'h401) return 8'hA8;
        if (v == 32'h451) return 8'hB8;
        return "?";
    endfunction

    function automatic void handle_char(logic [7:0] c);
        if (c == "<") begin
            mode = MODE_ANGLE;
            look_cnt = 0;
        end else if (c == "&") begin
            mode = MODE_AMP;
            look_cnt = 0;
        end else if (c == ">" && in_tag) begin
            hold_cnt = 0;
            in_tag = 1'b0;
        end else begin
            put_char(c);
        end
    endfunction

    // true when the first n lookahead bytes equal the start of pat
    function automatic bit look_matches(string pat, int n);
        for (int i = 0; i < n; i++)
            if (look_buf[i] != pat[i]) return 0;
        return 1;
    endfunction

    function automatic void resolve_mismatch();
        logic [7:0] tmp [LOOK_DEPTH];
        int n;
        t_mode m;
        n = look_cnt;
        m = mode;
        for (int i = 0; i < n; i++) tmp[i] = look_buf[i];
        look_cnt = 0;
        mode = MODE_TEXT;
        if (m == MODE_ANGLE) begin
            release_hold();
            in_tag = 1'b1;
        end else begin
            put_char("&");
        end
        for (int i = 0; i < n; i++) feed_byte(tmp[i]);
    endfunction

    function automatic void evaluate();
        string pats [7];
        logic [7:0] codes [7];
        int cnt;
        bit prefix;
        prefix = 0;
        if (mode == MODE_ANGLE) begin
            pats[0] = "br>"; pats[1] = "br />"; pats[2] = "/td>"; pats[3] = "p>";
            codes[0] = 8'd13; codes[1] = 8'd13; codes[2] = " "; codes[3] = 8'd13;
            cnt = 4;
        end else begin
            pats[0] = "quot;"; pats[1] = "nbsp;"; pats[2] = "lt;"; pats[3] = "gt;";
            pats[4] = "amp;"; pats[5] = "copy;"; pats[6] = "#";
            codes[0] = "\""; codes[1] = "_"; codes[2] = "<"; codes[3] = ">";
            codes[4] = "&"; codes[5] = 8'hA9; codes[6] = 8'h00;
            cnt = 7;
        end
        for (int i = 0; i < cnt; i++) begin
            if (pats[i].len() == look_cnt && look_matches(pats[i], look_cnt)) begin
                look_cnt = 0;
                if (mode == MODE_AMP && i == 6) begin
                    mode = MODE_NUM;
                    num_acc = '0;
                end else if (mode == MODE_ANGLE) begin
                    mode = MODE_TEXT;
                    put_char(codes[i]);
                end else begin
                    // decoded entity goes round again
                    mode = MODE_TEXT;
                    handle_char(codes[i]);
                end
                return;
            end
            if (pats[i].len() > look_cnt && look_matches(pats[i], look_cnt)) prefix = 1;
        end
        if (!prefix || look_cnt >= LOOK_DEPTH) resolve_mismatch();
    endfunction

    function automatic void feed_byte(logic [7:0] b);
        logic [7:0] c;
        if (mode == MODE_TEXT) begin
            handle_char(b);
        end else if (mode == MODE_NUM) begin
            if (b == ";") begin
                c = map_code(num_acc);
                num_acc = '0;
                mode = MODE_TEXT;
                handle_char(c);
            end else begin
                num_acc = num_acc * 32'd10 + 32'(b) - 32'd48;
            end
        end else if (look_cnt >= LOOK_DEPTH) begin
            resolve_mismatch();
            feed_byte(b);
        end else begin
            look_buf[look_cnt] = b;
            look_cnt++;
            evaluate();
        end
    endfunction

    function automatic void predict_word(logic [7:0] ch, logic last);
        step_bytes.delete();
        feed_byte(ch);
        if (last) begin
            while (mode == MODE_ANGLE || mode == MODE_AMP) resolve_mismatch();
            release_hold();
            clear_state();
        end
        if (step_bytes.size() > 0) begin
            step_bytes[$].run_last = 1'b1;
            step_bytes[$].text_done = last;
        end
        foreach (step_bytes[i]) expected_words.push_back(step_bytes[i]);
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        clear_state();
    end

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready) predict_word(i_s_tdata, i_s_tlast);
            if (i_m_tvalid && i_m_tready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch($sformatf("unexpected word %02h", i_m_tdata));
                end else begin
                    want = expected_words.pop_front();
                    if (i_m_tdata !== want.ch)
                        report_mismatch($sformatf("char %02h, want %02h",
                                                  i_m_tdata, want.ch));
                    if (i_m_tlast !== want.run_last)
                        report_mismatch($sformatf("run_last %b, want %b",
                                                  i_m_tlast, want.run_last));
                    if (i_m_tuser !== want.text_done)
                        report_mismatch($sformatf("text_done %b, want %b",
                                                  i_m_tuser, want.text_done));
                end
            end
        end
    end
endmodule

/* dv/tb_html_entity_tag_stripper_unit.sv */
module tb_html_entity_tag_stripper_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = '0;   // [7:0] in_char
    logic       s_axis_tlast = 1'b0; // text_end
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;        // [7:0] out_char
    logic       m_axis_tlast;        // run_last
    logic       m_axis_tuser;        // [0] text_done

    int fail_count;
    int words_pending;
    int cycle_count = 0;
    bit sink_long = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    html_entity_tag_stripper_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser)
    );

    hets_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_axis_tvalid),
        .i_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tlast   (s_axis_tlast),
        .i_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .i_m_tdata   (m_axis_tdata),
        .i_m_tlast   (m_axis_tlast),
        .i_m_tuser   (m_axis_tuser),
        .o_fail_count(fail_count),
        .o_pending   (words_pending)
    );

    // Pick a gap length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Timeout watchdog: count cycles and abort well past the slowest run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Sink: toggle ready with random stalls; some stretches run flat out.
    always @(posedge i_clk) begin
        if (!sink_long) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= (pick_gap() == 0);
        end
        if ($urandom_range(0, 199) == 0) sink_long <= !sink_long;
    end

    // Send one word and hold it until the handshake, with a random gap before.
    // Valid stays up after the handshake; a gap or the caller drops it.
    task automatic send_word(logic [7:0] ch, logic last, bit no_gap);
        int gap;
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic send_text(string txt, logic end_mark);
        for (int i = 0; i < txt.len(); i++)
            send_word(txt[i], end_mark && (i == txt.len() - 1), 0);
    endtask

    // Random well-formed fragment, now and then followed by one random payload byte.
    function automatic string pick_fragment();
        string frags [16];
        string s;
        frags[0] = "<br>"; frags[1] = "<br />"; frags[2] = "</td>"; frags[3] = "<p>";
        frags[4] = "&quot;"; frags[5] = "&nbsp;"; frags[6] = "&lt;"; frags[7] = "&gt;";
        frags[8] = "&amp;"; frags[9] = "&copy;"; frags[10] = "&#65;";
        frags[11] = "&#1040;"; frags[12] = "<b>"; frags[13] = "<div x>";
        frags[14] = "&#1105;"; frags[15] = "&#999999;";
        s = frags[$urandom_range(0, 15)];
        if ($urandom_range(0, 3) == 0) s = {s, string'(8'($urandom_range(0, 255)))};
        return s;
    endfunction

    initial begin
        string s;
        int sent;
        bit paused;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: each tag form, each entity, numeric mapping edges, hold overflow.
        send_text("a<br>b<br />c</td>d<p>e", 1);
        send_text("&quot;&nbsp;&lt;&gt;&amp;&copy;", 1);
        send_text("&#65;&#1025;&#1105;&#1103;&#5;", 1);
        send_text("<x>y>", 1);
        send_text("&lt;b&gt;z", 1);
        send_text("<abcdefghijklmnopqrstuvwxyz0123456789>", 1);
        send_text("<q<br", 1);
        send_text("&#12", 1);
        send_word(8'h00, 1'b0, 0);
        send_word(8'hFF, 1'b1, 0);
        send_word("<", 1'b1, 0);

        // Random part: mostly fragments, some raw noise bytes, texts of random length.
        sent = 0;
        paused = 0;
        while (sent < 16) begin
            if ($urandom_range(0, 4) == 0) s = string'(8'($urandom_range(0, 255)));
            else s = pick_fragment();
            for (int i = 0; i < s.len(); i++) begin
                send_word(s[i], ($urandom_range(0, 11) == 0), 0);
                sent++;
            end
            // Hold the sender off until all outstanding output has drained.
            if (!paused && sent > 8) begin
                paused = 1;
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
                while (words_pending != 0) @(posedge i_clk);
            end
        end
        send_word("x", 1'b1, 0);
        s_axis_tvalid <= 1'b0;

        while (words_pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && words_pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
